[src/csi_motion_detector_core_macros.svh]
// Assertion macros used by the motion detector core.
`ifndef CSI_MOTION_DETECTOR_CORE_MACROS_SVH
`define CSI_MOTION_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CSIMD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSIMD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CSIMD_ASSERT(label, clk, rst, prop, msg)
`define CSIMD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[src/csimd_pkg.sv]
package csimd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_WEIGHT        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_GAIN         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_ALPHA        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONSECUTIVE_NEEDED = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS         = 3'd5;

   localparam int FRAC_W   = 16;
   localparam int BASE_W   = 24;
   localparam int SMOOTH_W = 23;
   localparam int MUL_A_W  = 24;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = 41;
   localparam int LEVEL_W  = 7;
   localparam int RUN_W    = 8;
   localparam int HOLD_W   = 32;
   localparam int COUNT_W  = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DEV,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_MUL5,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MUL_BASE,
      MUL_METRIC,
      MUL_DEV,
      MUL_SMOOTH,
      MUL_LEVEL
   } mul_sel_type;

   typedef struct packed {
      logic [15:0] base_weight;
      logic [15:0] level_gain;
      logic [15:0] level_alpha;
      logic [14:0] motion_threshold;
      logic [7:0]  consecutive_needed;
      logic [31:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic        take_byte;
      logic        take_tick;
      logic        div_init;
      logic        div_step;
      logic        seed_dev;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        base_upd;
      logic        lvl_upd;
      logic        smooth_upd;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic counted_zero;
      logic div_last;
   } status_type;

endpackage

[src/csimd_ctrl.sv]
module csimd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_opcode,
   input  logic                  req_last,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  csimd_pkg::status_type status,
   output csimd_pkg::cmd_type    cmd
);

   csimd_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csimd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = csimd_pkg::MUL_BASE;
      req_tready  = 1'b0;
      unique case (state_ff)
         csimd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_opcode) begin
                  cmd.take_tick = 1'b1;
               end else begin
                  cmd.take_byte = 1'b1;
                  if (req_last) begin
                     state_in = csimd_pkg::ST_CHECK;
                  end
               end
            end
         end
         csimd_pkg::ST_CHECK: begin
            cmd.div_init = 1'b1;
            state_in = status.counted_zero ? csimd_pkg::ST_OUT : csimd_pkg::ST_DIV;
         end
         csimd_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = csimd_pkg::ST_DEV;
            end
         end
         csimd_pkg::ST_DEV: begin
            cmd.seed_dev = 1'b1;
            state_in = csimd_pkg::ST_MUL0;
         end
         csimd_pkg::ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = csimd_pkg::MUL_BASE;
            state_in = csimd_pkg::ST_MUL1;
         end
         csimd_pkg::ST_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = csimd_pkg::MUL_METRIC;
            cmd.acc_load = 1'b1;
            state_in = csimd_pkg::ST_MUL2;
         end
         csimd_pkg::ST_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = csimd_pkg::MUL_DEV;
            cmd.base_upd = 1'b1;
            state_in = csimd_pkg::ST_MUL3;
         end
         csimd_pkg::ST_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = csimd_pkg::MUL_SMOOTH;
            cmd.lvl_upd = 1'b1;
            state_in = csimd_pkg::ST_MUL4;
         end
         csimd_pkg::ST_MUL4: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = csimd_pkg::MUL_LEVEL;
            cmd.acc_load = 1'b1;
            state_in = csimd_pkg::ST_MUL5;
         end
         csimd_pkg::ST_MUL5: begin
            cmd.smooth_upd = 1'b1;
            state_in = csimd_pkg::ST_OUT;
         end
         csimd_pkg::ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = csimd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csimd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/csimd_datapath.sv]
module csimd_datapath #(
   parameter int MAX_PACKET_BYTES = 1024,
   parameter int LEAD_SKIP        = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csimd_pkg::cmd_type    cmd,
   input  csimd_pkg::cfg_type    cfg,
   input  logic signed [7:0]     csi_value,
   input  logic                  skip_lead,
   output csimd_pkg::status_type status,
   output logic [6:0]            signal_level,
   output logic                  motion,
   output logic [31:0]           packets_seen,
   output logic                  packet_used
);

   localparam int FRAC_W   = csimd_pkg::FRAC_W;
   localparam int BASE_W   = csimd_pkg::BASE_W;
   localparam int SMOOTH_W = csimd_pkg::SMOOTH_W;
   localparam int MUL_A_W  = csimd_pkg::MUL_A_W;
   localparam int MUL_B_W  = csimd_pkg::MUL_B_W;
   localparam int PROD_W   = csimd_pkg::PROD_W;
   localparam int LEVEL_W  = csimd_pkg::LEVEL_W;
   localparam int RUN_W    = csimd_pkg::RUN_W;
   localparam int HOLD_W   = csimd_pkg::HOLD_W;
   localparam int COUNT_W  = csimd_pkg::COUNT_W;
   localparam int SUM_W    = $clog2(MAX_PACKET_BYTES * 128 + 1);
   localparam int CW       = $clog2(MAX_PACKET_BYTES + 1);
   localparam int QW       = SUM_W + FRAC_W;
   localparam int DCNT_W   = $clog2(QW);
   localparam logic [MUL_B_W-1:0] ONE_Q16 = MUL_B_W'(1) << FRAC_W;

   // packet accumulators
   logic [SUM_W-1:0]    sum_ff;
   logic [CW-1:0]       counted_ff;
   logic [CW-1:0]       pos_ff;
   // divider
   logic [QW-1:0]       div_q_ff;
   logic [CW:0]         div_rem_ff;
   logic [DCNT_W-1:0]   div_cnt_ff;
   // packet state
   logic [BASE_W-1:0]   baseline_ff;
   logic                base_valid_ff;
   logic [BASE_W-1:0]   dev_ff;
   logic [SMOOTH_W-1:0] smooth_ff;
   logic [LEVEL_W-1:0]  lvl_ff;
   logic [RUN_W-1:0]    run_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   acc_ff;

   logic [7:0]          mag;
   logic                counts;
   logic [CW:0]         rem_shift;
   logic                rem_ge;
   logic [BASE_W-1:0]   metric;
   logic [BASE_W-1:0]   base_eff;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W:0]     base_sum;
   logic [PROD_W:0]     smooth_sum;
   logic [15:0]         lvl_raw;
   logic                over;
   logic [RUN_W-1:0]    run_inc;

   assign mag = csi_value[7] ? (8'd0 - $unsigned(csi_value)) : $unsigned(csi_value);
   assign counts = (pos_ff < CW'(MAX_PACKET_BYTES))
                   && !(skip_lead && (pos_ff < CW'(LEAD_SKIP)));

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         counted_ff <= '0;
         pos_ff     <= '0;
      end else if (cmd.out_load) begin
         sum_ff     <= '0;
         counted_ff <= '0;
         pos_ff     <= '0;
      end else if (cmd.take_byte && (pos_ff < CW'(MAX_PACKET_BYTES))) begin
         if (counts) begin
            sum_ff     <= sum_ff + SUM_W'(mag);
            counted_ff <= counted_ff + CW'(1);
         end
         pos_ff <= pos_ff + CW'(1);
      end
   end

   // restoring division, one quotient bit per cycle: (sum << 16) / counted
   assign rem_shift = {div_rem_ff[CW-1:0], div_q_ff[QW-1]};
   assign rem_ge    = rem_shift >= {1'b0, counted_ff};
   assign metric    = div_q_ff[BASE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_q_ff   <= {sum_ff, {FRAC_W{1'b0}}};
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_q_ff   <= {div_q_ff[QW-2:0], rem_ge};
         div_rem_ff <= rem_ge ? (rem_shift - {1'b0, counted_ff}) : rem_shift;
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
   end

   assign status.counted_zero = (counted_ff == '0);
   assign status.div_last     = (div_cnt_ff == DCNT_W'(QW - 1));

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         csimd_pkg::MUL_BASE: begin
            mul_a = baseline_ff;
            mul_b = ONE_Q16 - {1'b0, cfg.base_weight};
         end
         csimd_pkg::MUL_METRIC: begin
            mul_a = metric;
            mul_b = {1'b0, cfg.base_weight};
         end
         csimd_pkg::MUL_DEV: begin
            mul_a = dev_ff;
            mul_b = {1'b0, cfg.level_gain};
         end
         csimd_pkg::MUL_SMOOTH: begin
            mul_a = {1'b0, smooth_ff};
            mul_b = ONE_Q16 - {1'b0, cfg.level_alpha};
         end
         csimd_pkg::MUL_LEVEL: begin
            mul_a = MUL_A_W'(lvl_ff);
            mul_b = {1'b0, cfg.level_alpha};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign base_eff   = base_valid_ff ? baseline_ff : metric;
   assign base_sum   = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign smooth_sum = {1'b0, acc_ff} + ({1'b0, prod_ff} << FRAC_W);
   assign lvl_raw    = prod_ff[39:24];
   assign over       = dev_ff > {1'b0, cfg.motion_threshold, 8'd0};
   assign run_inc    = (run_ff != {RUN_W{1'b1}}) ? run_ff + RUN_W'(1) : run_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end
      if (cmd.seed_dev) begin
         dev_ff <= (metric >= base_eff) ? (metric - base_eff) : (base_eff - metric);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= '0;
         base_valid_ff <= 1'b0;
         smooth_ff     <= '0;
         lvl_ff        <= '0;
         run_ff        <= '0;
         hold_ff       <= '0;
         count_ff      <= '0;
      end else begin
         if (cmd.seed_dev && !base_valid_ff) begin
            baseline_ff   <= metric;
            base_valid_ff <= 1'b1;
         end
         if (cmd.base_upd) begin
            baseline_ff <= base_sum[FRAC_W+BASE_W-1:FRAC_W];
         end
         if (cmd.lvl_upd) begin
            lvl_ff <= (lvl_raw > {9'd0, csimd_pkg::LEVEL_MAX})
                      ? csimd_pkg::LEVEL_MAX : lvl_raw[LEVEL_W-1:0];
         end
         if (cmd.smooth_upd) begin
            smooth_ff <= smooth_sum[FRAC_W+SMOOTH_W-1:FRAC_W];
            count_ff  <= count_ff + COUNT_W'(1);
            if (over) begin
               run_ff <= run_inc;
               if (run_inc >= cfg.consecutive_needed) begin
                  hold_ff <= cfg.hold_ticks;
               end
            end else begin
               run_ff <= '0;
            end
         end else if (cmd.take_tick && (hold_ff != '0)) begin
            hold_ff <= hold_ff - HOLD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         signal_level <= smooth_ff[SMOOTH_W-1:FRAC_W];
         motion       <= (hold_ff != '0);
         packets_seen <= count_ff;
         packet_used  <= (counted_ff != '0);
      end
   end

endmodule

[src/csi_motion_detector_core.sv]
// Channel-state motion detector.
// req channel: one transaction per channel-state byte or time tick. A byte
//    transaction with tlast ends the packet; tuser[0] = 1 marks a tick.
// rsp channel: one transaction per packet end with the level, the motion flag,
//    the packet count and the packet-used flag.
// csr channel: register writes, always ready; write only while idle.
// Bytes and ticks are taken one per cycle while the input is not stalled. After
//    the last byte of a packet the input stalls while the result is worked
//    out: a check state, the divider steps for the QW quotient bits (QW =
//    clog2(128*MAX_PACKET_BYTES+1) + 16, 34 at default), a deviation state,
//    six steps on the shared multiplier and an output state. A packet with no
//    counted bytes goes from the check state straight to the output state.
// A finished result sits in the output register; further bytes are taken
//    while it waits, and only the next packet end stalls until it is taken.
// Reset clears the detector state and loads the default register values.
`include "csi_motion_detector_core_macros.svh"

module csi_motion_detector_core #(
   parameter int MAX_PACKET_BYTES = 1024,
   parameter int LEAD_SKIP        = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] csi_value
   input  logic [1:0]  req_tuser,   // [0] opcode, [1] skip_lead
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [6:0] signal_level, [7] motion, [39:8] packets_seen
   output logic [0:0]  rsp_tuser,   // [0] packet_used
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   csimd_pkg::cfg_type    cfg_ff;
   csimd_pkg::cmd_type    cmd;
   csimd_pkg::status_type status;
   logic [6:0]            signal_level;
   logic                  motion;
   logic [31:0]           packets_seen;
   logic                  packet_used;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_weight        <= 16'd1311;
         cfg_ff.level_gain         <= 16'd1024;
         cfg_ff.level_alpha        <= 16'd19661;
         cfg_ff.motion_threshold   <= 15'd307;
         cfg_ff.consecutive_needed <= 8'd2;
         cfg_ff.hold_ticks         <= 32'd2000000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            csimd_pkg::CSR_BASE_WEIGHT:        cfg_ff.base_weight        <= csr_data[15:0];
            csimd_pkg::CSR_LEVEL_GAIN:         cfg_ff.level_gain         <= csr_data[15:0];
            csimd_pkg::CSR_LEVEL_ALPHA:        cfg_ff.level_alpha        <= csr_data[15:0];
            csimd_pkg::CSR_MOTION_THRESHOLD:   cfg_ff.motion_threshold   <= csr_data[14:0];
            csimd_pkg::CSR_CONSECUTIVE_NEEDED: cfg_ff.consecutive_needed <= csr_data[7:0];
            csimd_pkg::CSR_HOLD_TICKS:         cfg_ff.hold_ticks         <= csr_data;
            default: begin
            end
         endcase
      end
   end

   csimd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser[0]),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   csimd_datapath #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .LEAD_SKIP        (LEAD_SKIP)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg_ff),
      .csi_value    ($signed(req_tdata)),
      .skip_lead    (req_tuser[1]),
      .status       (status),
      .signal_level (signal_level),
      .motion       (motion),
      .packets_seen (packets_seen),
      .packet_used  (packet_used)
   );

   assign rsp_tdata = {packets_seen, motion, signal_level};
   assign rsp_tuser = packet_used;

   `CSIMD_ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.out_load && rsp_tvalid && !rsp_tready, "result overwritten before taken")
   `CSIMD_ASSERT(a_level_range, clock, reset, rsp_tvalid |-> (rsp_tdata[6:0] <= 7'd100), "signal level above 100")
   `CSIMD_ASSERT(a_take_on_accept, clock, reset, (cmd.take_byte || cmd.take_tick) |-> (req_tvalid && req_tready), "item taken without a transaction")

endmodule
